// ===== hdl/additive_feedback_random_generator_core_assert.svh =====
// assertion macros for the additive feedback random generator core
// expects clk and rst in the scope of the module that uses them
`ifndef ADDITIVE_FEEDBACK_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define ADDITIVE_FEEDBACK_RANDOM_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define AFRG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrg assertion failed");

// next-cycle implication
`define AFRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afrg assertion failed");

`endif

// ===== hdl/afrg_pkg.sv =====
// shared types, constants and the microcode program of the generator core
// no dependencies
`timescale 1ns / 1ps

package afrg_pkg;

  localparam int WORD_W     = 32;
  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = 5;
  localparam int PC_W       = 4;
  localparam int WARM_W     = 9;
  localparam int QUOT_W     = 16;
  localparam int RECIP_SHIFT = 48;

  localparam logic [RING_AW-1:0] RESET_INDEX   = 5'd24;
  localparam logic [RING_AW-1:0] LAG_OFFSET    = 5'd29;
  localparam logic [RING_AW-1:0] RESTART_INDEX = 5'd2;
  localparam logic [RING_AW-1:0] FILL_FIRST    = 5'd1;
  localparam logic [RING_AW-1:0] FILL_SECOND   = 5'd2;
  localparam logic [RING_AW-1:0] FILL_LAST     = 5'd30;
  localparam logic [RING_AW-1:0] TOP_INDEX     = 5'd31;
  localparam logic [RING_AW-1:0] LOW0_INDEX    = 5'd0;
  localparam logic [RING_AW-1:0] LOW1_INDEX    = 5'd1;

  localparam logic [14:0] LEHMER_A  = 15'd16807;
  localparam logic [16:0] SCHRAGE_Q = 17'd127773;
  localparam logic [11:0] SCHRAGE_R = 12'd2836;
  localparam logic [WORD_W-1:0] LEHMER_M = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SCHRAGE_RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'd127773);

  localparam int WARMUP_DRAWS = 310;
  localparam logic [WARM_W-1:0] WARM_LOAD = 9'(WARMUP_DRAWS - 1);

  localparam logic [WORD_W-1:0] RING_INIT [RING_DEPTH] = '{
    32'hdb48f936, 32'h14898454, 32'h37ffd106, 32'hb58bff9c,
    32'h59e17104, 32'hcf918a49, 32'h09378c83, 32'h52c7a471,
    32'h8d293ea9, 32'h1f4fc301, 32'hc3db71be, 32'h39b44e1c,
    32'hf8a44ef9, 32'h4c8b80b1, 32'h19edc328, 32'h87bf4bdd,
    32'hc9b240e5, 32'he9ee4b1b, 32'h4382aee7, 32'h535b6b41,
    32'hf3bec5da, 32'h991539b1, 32'h16a5bce3, 32'h6774a4cd,
    32'h73b5def3, 32'h3e01511e, 32'h4e508aaa, 32'h61048c05,
    32'hf5500617, 32'h846b7115, 32'h6a19892c, 32'h896a97af
  };

  // datapath operations
  localparam logic [3:0] OP_IDLE = 4'd0;
  localparam logic [3:0] OP_EMIT = 4'd1;
  localparam logic [3:0] OP_SEED = 4'd2;
  localparam logic [3:0] OP_WAIT = 4'd3;
  localparam logic [3:0] OP_FILL = 4'd4;
  localparam logic [3:0] OP_TOP  = 4'd5;
  localparam logic [3:0] OP_LOW0 = 4'd6;
  localparam logic [3:0] OP_LOW1 = 4'd7;
  localparam logic [3:0] OP_READ = 4'd8;
  localparam logic [3:0] OP_WARM = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NONE   = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_SEED   = 3'd2;
  localparam logic [2:0] C_FILL   = 3'd3;
  localparam logic [2:0] C_WARM   = 3'd4;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_EMIT = 4'd1;
  localparam logic [PC_W-1:0] PC_SEED = 4'd2;
  localparam logic [PC_W-1:0] PC_MAG  = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL  = 4'd4;
  localparam logic [PC_W-1:0] PC_EST  = 4'd5;
  localparam logic [PC_W-1:0] PC_FIX  = 4'd6;
  localparam logic [PC_W-1:0] PC_PROD = 4'd7;
  localparam logic [PC_W-1:0] PC_FILL = 4'd8;
  localparam logic [PC_W-1:0] PC_TOP  = 4'd9;
  localparam logic [PC_W-1:0] PC_LOW0 = 4'd10;
  localparam logic [PC_W-1:0] PC_LOW1 = 4'd11;
  localparam logic [PC_W-1:0] PC_WRD  = 4'd12;
  localparam logic [PC_W-1:0] PC_WWR  = 4'd13;
  localparam logic [PC_W-1:0] PC_BACK = 4'd14;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic stall;
    logic seed;
    logic fill_more;
    logic warm_more;
  } status_t;

  function automatic ctrl_t program_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE: w = '{op: OP_IDLE, cond: C_SEED,   target: PC_SEED};
      PC_EMIT: w = '{op: OP_EMIT, cond: C_ALWAYS, target: PC_IDLE};
      PC_SEED: w = '{op: OP_SEED, cond: C_NONE,   target: PC_IDLE};
      PC_MAG:  w = '{op: OP_WAIT, cond: C_NONE,   target: PC_IDLE};
      PC_MUL:  w = '{op: OP_WAIT, cond: C_NONE,   target: PC_IDLE};
      PC_EST:  w = '{op: OP_WAIT, cond: C_NONE,   target: PC_IDLE};
      PC_FIX:  w = '{op: OP_WAIT, cond: C_NONE,   target: PC_IDLE};
      PC_PROD: w = '{op: OP_WAIT, cond: C_NONE,   target: PC_IDLE};
      PC_FILL: w = '{op: OP_FILL, cond: C_FILL,   target: PC_MAG};
      PC_TOP:  w = '{op: OP_TOP,  cond: C_NONE,   target: PC_IDLE};
      PC_LOW0: w = '{op: OP_LOW0, cond: C_NONE,   target: PC_IDLE};
      PC_LOW1: w = '{op: OP_LOW1, cond: C_NONE,   target: PC_IDLE};
      PC_WRD:  w = '{op: OP_READ, cond: C_NONE,   target: PC_IDLE};
      PC_WWR:  w = '{op: OP_WARM, cond: C_WARM,   target: PC_WRD};
      PC_BACK: w = '{op: OP_WAIT, cond: C_ALWAYS, target: PC_IDLE};
      default: w = '{op: OP_WAIT, cond: C_ALWAYS, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/afrg_seq.sv =====
// microcode sequencer: step counter, program table and conditional jumps
// depends on afrg_pkg
`timescale 1ns / 1ps

module afrg_seq (
  input  logic             clk,
  input  logic             rst,
  input  afrg_pkg::status_t status,
  output afrg_pkg::ctrl_t   ctrl
);
  import afrg_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctrl = program_word(pc);

  always_comb begin
    case (ctrl.cond)
      C_NONE:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_SEED:   take = status.seed;
      C_FILL:   take = status.fill_more;
      C_WARM:   take = status.warm_more;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    if (status.stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/afrg_schrage.sv =====
// five-stage schrage-form lehmer step, signed truncating division by reciprocal
// depends on afrg_pkg
`timescale 1ns / 1ps

module afrg_schrage (
  input  logic        clk,
  input  logic [31:0] r,
  output logic [31:0] r_next
);
  import afrg_pkg::*;

  logic                neg1, neg2, neg3, neg4, neg5;
  logic [WORD_W-1:0]   mag1, mag2;
  logic [63:0]         prod2;
  logic [QUOT_W-1:0]   q_est, q3, q4;
  logic [32:0]         qd;
  logic [17:0]         rem3;
  logic [16:0]         rem4;
  logic [31:0]         p1;
  logic [27:0]         p2;
  logic [WORD_W-1:0]   t;

  assign q_est = prod2[RECIP_SHIFT +: QUOT_W];
  assign qd    = 33'(q_est) * 33'(SCHRAGE_Q);

  always_ff @(posedge clk) begin
    // magnitude
    neg1 <= r[31];
    mag1 <= r[31] ? (~r + 32'd1) : r;
    // reciprocal multiply
    neg2  <= neg1;
    mag2  <= mag1;
    prod2 <= 64'(mag1) * 64'(SCHRAGE_RECIP);
    // quotient estimate and remainder
    neg3 <= neg2;
    q3   <= q_est;
    rem3 <= 18'(mag2 - qd[31:0]);
    // one correction
    neg4 <= neg3;
    if (rem3 >= 18'(SCHRAGE_Q)) begin
      q4   <= q3 + 16'd1;
      rem4 <= 17'(rem3 - 18'(SCHRAGE_Q));
    end else begin
      q4   <= q3;
      rem4 <= rem3[16:0];
    end
    // products
    neg5 <= neg4;
    p1   <= 32'(rem4) * 32'(LEHMER_A);
    p2   <= 28'(q4) * 28'(SCHRAGE_R);
  end

  assign t      = neg5 ? (32'(p2) - p1) : (p1 - 32'(p2));
  assign r_next = t[31] ? (t + LEHMER_M) : t;

endmodule

// ===== hdl/additive_feedback_random_generator_core.sv =====
// additive lagged-fibonacci generator core over a 32-word ring
// draw: ring read registered in idle; the emit step sums, writes back and registers
// the value, stalling while the last value is not taken; only idle accepts requests
// reseed: busy after accept for 30 six-step lehmer fills and 310 two-step draws
// rst clears the sequencer, sets the index to 24, ring reads the reset table
`timescale 1ns / 1ps
`include "additive_feedback_random_generator_core_assert.svh"

module additive_feedback_random_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);
  import afrg_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic                  in_accept;
  logic                  out_block;
  logic [RING_AW-1:0]    idx;
  logic [RING_AW-1:0]    fill_i;
  logic [WARM_W-1:0]     warm_cnt;
  logic [WORD_W-1:0]     seed_word;
  logic [WORD_W-1:0]     r_word;
  logic [WORD_W-1:0]     r_next;
  logic [WORD_W-1:0]     low0;
  logic [WORD_W-1:0]     low1;
  logic [WORD_W-1:0]     rd_a;
  logic [WORD_W-1:0]     rd_b;
  logic [WORD_W-1:0]     sum;
  logic [RING_AW-1:0]    addr_a;
  logic [RING_AW-1:0]    addr_b;
  logic                  wr_en;
  logic [RING_AW-1:0]    wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [WORD_W-1:0]     ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_ok;

  afrg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  afrg_schrage u_schrage (
    .clk    (clk),
    .r      (r_word),
    .r_next (r_next)
  );

  assign in_ready  = (ctrl.op == OP_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_block = out_valid && !out_ready;

  assign status.stall     = ((ctrl.op == OP_IDLE) && !in_accept) ||
                            ((ctrl.op == OP_EMIT) && out_block);
  assign status.seed      = kind;
  assign status.fill_more = (fill_i != FILL_LAST);
  assign status.warm_more = (warm_cnt != '0);

  assign addr_a = idx + LAG_OFFSET;
  assign addr_b = idx + 5'd1;
  assign sum    = rd_a + rd_b;

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = sum;
    case (ctrl.op)
      OP_EMIT: begin
        wr_en = !out_block;
      end
      OP_WARM: begin
        wr_en = 1'b1;
      end
      OP_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_i;
        wr_data = r_next;
      end
      OP_TOP: begin
        wr_en   = 1'b1;
        wr_addr = TOP_INDEX;
        wr_data = seed_word;
      end
      OP_LOW0: begin
        wr_en   = 1'b1;
        wr_addr = LOW0_INDEX;
        wr_data = low0;
      end
      OP_LOW1: begin
        wr_en   = 1'b1;
        wr_addr = LOW1_INDEX;
        wr_data = low1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // ring memory, unwritten entries read as the reset table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if ((ctrl.op == OP_IDLE) || (ctrl.op == OP_READ)) begin
      rd_a <= ring_ok[addr_a] ? ring[addr_a] : RING_INIT[addr_a];
      rd_b <= ring_ok[addr_b] ? ring[addr_b] : RING_INIT[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ok <= '0;
    end else if (wr_en) begin
      ring_ok[wr_addr] <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= RESET_INDEX;
      fill_i    <= FILL_FIRST;
      warm_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_EMIT: begin
          if (!out_block) begin
            out_valid <= 1'b1;
            idx       <= idx + 5'd1;
          end
        end
        OP_WARM: begin
          idx      <= idx + 5'd1;
          warm_cnt <= warm_cnt - 9'd1;
        end
        OP_SEED: begin
          fill_i <= FILL_FIRST;
        end
        OP_FILL: begin
          fill_i <= fill_i + 5'd1;
        end
        OP_LOW1: begin
          idx      <= RESTART_INDEX;
          warm_cnt <= WARM_LOAD;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_EMIT) && !out_block) begin
      value <= sum;
    end
    if (in_accept) begin
      seed_word <= (seed == '0) ? 32'd1 : seed;
    end
    if (ctrl.op == OP_SEED) begin
      r_word <= seed_word;
    end
    if (ctrl.op == OP_FILL) begin
      r_word <= r_next;
      if (fill_i == FILL_FIRST) begin
        low0 <= r_next;
      end
      if (fill_i == FILL_SECOND) begin
        low1 <= r_next;
      end
    end
  end

  `AFRG_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
  `AFRG_ASSERT_NOW(a_fill_range, ctrl.op == OP_FILL, fill_i >= FILL_FIRST && fill_i <= FILL_LAST)
  `AFRG_ASSERT_NOW(a_fill_below_modulus, ctrl.op == OP_FILL, !r_next[31])
  `AFRG_ASSERT_NEXT(a_warmup_silent, ctrl.op == OP_WARM && !out_valid, !out_valid)

endmodule
